### rtl/two_way_run_merger_defines.svh
// Assertion macros for the merger's checker file.
`ifndef TWO_WAY_RUN_MERGER_DEFINES_SVH
`define TWO_WAY_RUN_MERGER_DEFINES_SVH

// Clocked assertion, off while reset is high.
`define TWRM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define TWRM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/twrm_pkg.sv
// Shared constants, state encoding and control/status types for the run merger.
package twrm_pkg;

  localparam int FIFO_DEPTH = 32;
  localparam int ELEM_W     = 64;
  localparam int AW         = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW         = $clog2(FIFO_DEPTH + 1);
  localparam int SW         = CW + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_OVF,
    ST_CHECK,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic take;
    logic load_ovf;
    logic pop_emit;
    logic clear_ended;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_ovf;
    logic more;
    logic done;
    logic out_free;
  } status_t;

endpackage

### rtl/twrm_if.sv
// Valid/ready channel interfaces for input items and merged result items.
interface twrm_in_if;
  import twrm_pkg::*;

  logic              valid;
  logic              ready;
  logic              run_select;
  logic              has_value;
  logic [ELEM_W-1:0] element_bits;
  logic              run_end;

  modport source (output valid, output run_select, output has_value,
                  output element_bits, output run_end, input ready);
  modport sink   (input valid, input run_select, input has_value,
                  input element_bits, input run_end, output ready);
endinterface

interface twrm_out_if;
  import twrm_pkg::*;

  logic              valid;
  logic              ready;
  logic [ELEM_W-1:0] merged_bits;
  logic              final_item;
  logic              overflow;

  modport source (output valid, output merged_bits, output final_item,
                  output overflow, input ready);
  modport sink   (input valid, input merged_bits, input final_item,
                  input overflow, output ready);
endinterface

### rtl/twrm_ctrl.sv
// Sequencer for the run merger: item intake, overflow reply and merge loop.
module twrm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  twrm_pkg::status_t  status,
  output twrm_pkg::cmd_t     cmd
);
  import twrm_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (status.in_valid) begin
          state_next = status.in_ovf ? ST_OVF : ST_CHECK;
        end
      end
      ST_OVF: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_CHECK: begin
        state_next = status.more ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          state_next = ST_CHECK;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        cmd.take = 1'b1;
      end
      ST_OVF: begin
        cmd.load_ovf = status.out_free;
      end
      ST_CHECK: begin
        cmd.clear_ended = !status.more && status.done;
      end
      ST_EMIT: begin
        cmd.pop_emit = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

### rtl/twrm_datapath.sv
// Run FIFOs, head compare, run state and output register of the run merger.
module twrm_datapath (
  input  logic               clk,
  input  logic               rst,
  twrm_in_if.sink            feed,
  twrm_out_if.source         merged,
  input  twrm_pkg::cmd_t     cmd,
  output twrm_pkg::status_t  status
);
  import twrm_pkg::*;

  logic [ELEM_W-1:0] mem_a [FIFO_DEPTH];
  logic [ELEM_W-1:0] mem_b [FIFO_DEPTH];
  logic [ELEM_W-1:0] rd_a;
  logic [ELEM_W-1:0] rd_b;
  logic [CW-1:0]     cnt_a;
  logic [CW-1:0]     cnt_b;
  logic [AW-1:0]     head_a;
  logic [AW-1:0]     head_b;
  logic              ended_a;
  logic              ended_b;
  logic              out_valid;
  logic [ELEM_W-1:0] out_bits;
  logic              out_final;
  logic              out_ovf;

  logic              ended_sel;
  logic [CW-1:0]     cnt_sel;
  logic              in_ovf;
  logic              do_item;
  logic              push_a;
  logic              push_b;
  logic [SW-1:0]     sum_a;
  logic [SW-1:0]     sum_b;
  logic [AW-1:0]     tail_a;
  logic [AW-1:0]     tail_b;
  logic              take_a;
  logic              is_final;
  logic              out_free;

  function automatic logic [ELEM_W-1:0] order_key(input logic [ELEM_W-1:0] bits);
    if (bits[ELEM_W-1]) begin
      return ~bits;
    end
    return {1'b1, bits[ELEM_W-2:0]};
  endfunction

  function automatic logic less_or_equal(input logic [ELEM_W-1:0] a,
                                         input logic [ELEM_W-1:0] b);
    if ((a[ELEM_W-2:0] | b[ELEM_W-2:0]) == '0) begin
      return 1'b1;
    end
    return order_key(a) <= order_key(b);
  endfunction

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    if (p == AW'(FIFO_DEPTH - 1)) begin
      return '0;
    end
    return p + AW'(1);
  endfunction

  assign ended_sel = feed.run_select ? ended_b : ended_a;
  assign cnt_sel   = feed.run_select ? cnt_b : cnt_a;
  assign in_ovf    = !ended_sel && feed.has_value && (cnt_sel == CW'(FIFO_DEPTH));
  assign do_item   = feed.valid && cmd.take && !in_ovf && !ended_sel;
  assign push_a    = do_item && !feed.run_select && feed.has_value;
  assign push_b    = do_item && feed.run_select && feed.has_value;

  assign sum_a  = SW'(head_a) + SW'(cnt_a);
  assign sum_b  = SW'(head_b) + SW'(cnt_b);
  assign tail_a = (sum_a >= SW'(FIFO_DEPTH)) ? AW'(sum_a - SW'(FIFO_DEPTH)) : AW'(sum_a);
  assign tail_b = (sum_b >= SW'(FIFO_DEPTH)) ? AW'(sum_b - SW'(FIFO_DEPTH)) : AW'(sum_b);

  assign take_a   = (cnt_a != '0 && cnt_b != '0) ? less_or_equal(rd_a, rd_b)
                                                  : (cnt_a != '0);
  assign is_final = ended_a && ended_b &&
                    ((cnt_a == CW'(1) && cnt_b == '0) || (cnt_a == '0 && cnt_b == CW'(1)));
  assign out_free = !out_valid || merged.ready;

  assign feed.ready      = cmd.take;
  assign status.in_valid = feed.valid;
  assign status.in_ovf   = in_ovf;
  assign status.more     = (cnt_a != '0 || ended_a) && (cnt_b != '0 || ended_b) &&
                           (cnt_a != '0 || cnt_b != '0);
  assign status.done     = ended_a && ended_b && cnt_a == '0 && cnt_b == '0;
  assign status.out_free = out_free;

  assign merged.valid       = out_valid;
  assign merged.merged_bits = out_bits;
  assign merged.final_item  = out_final;
  assign merged.overflow    = out_ovf;

  always_ff @(posedge clk) begin
    if (push_a) begin
      mem_a[tail_a] <= feed.element_bits;
    end
    rd_a <= mem_a[head_a];
  end

  always_ff @(posedge clk) begin
    if (push_b) begin
      mem_b[tail_b] <= feed.element_bits;
    end
    rd_b <= mem_b[head_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_a   <= '0;
      cnt_b   <= '0;
      head_a  <= '0;
      head_b  <= '0;
      ended_a <= 1'b0;
      ended_b <= 1'b0;
    end else begin
      if (push_a) begin
        cnt_a <= cnt_a + CW'(1);
      end
      if (push_b) begin
        cnt_b <= cnt_b + CW'(1);
      end
      if (do_item && feed.run_end) begin
        if (feed.run_select) begin
          ended_b <= 1'b1;
        end else begin
          ended_a <= 1'b1;
        end
      end
      if (cmd.pop_emit) begin
        if (take_a) begin
          head_a <= wrap_inc(head_a);
          cnt_a  <= cnt_a - CW'(1);
        end else begin
          head_b <= wrap_inc(head_b);
          cnt_b  <= cnt_b - CW'(1);
        end
      end
      if (cmd.clear_ended) begin
        ended_a <= 1'b0;
        ended_b <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_ovf || cmd.pop_emit) begin
      out_valid <= 1'b1;
    end else if (merged.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_ovf) begin
      out_bits  <= '0;
      out_final <= 1'b0;
      out_ovf   <= 1'b1;
    end else if (cmd.pop_emit) begin
      out_bits  <= take_a ? rd_a : rd_b;
      out_final <= is_final;
      out_ovf   <= 1'b0;
    end
  end

endmodule

### rtl/two_way_run_merger.sv
// Two-way merger of ascending runs of IEEE-754 doubles, ties to run A.
// Items tagged with their run are queued in one 32-entry FIFO per run; once
// each run has a queued head or has ended, the smaller head goes out, both
// zeros comparing equal, and after a run ends the other drains completely. An
// item is taken in the idle state only, and the block then decides in a check
// state whether anything can be emitted. Each emitted element passes through
// the check state, which reads both FIFO heads from their registered memory
// ports, and the emit state, which compares them and loads the output
// register, waiting while the output is stalled. An item pushed to a full
// FIFO is dropped and answered by one overflow result.
// The FIFO memories need no clearing after reset.
module two_way_run_merger (
  input  logic       clk,
  input  logic       rst,
  twrm_in_if.sink    feed,
  twrm_out_if.source merged
);
  import twrm_pkg::*;

  cmd_t    cmd;
  status_t status;

  twrm_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  twrm_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .feed   (feed),
    .merged (merged),
    .cmd    (cmd),
    .status (status)
  );

endmodule

### rtl/twrm_checker.sv
// Port-level checks on the run merger and their binding to the top level.
`include "two_way_run_merger_defines.svh"

module twrm_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_bits,
  input logic        out_final,
  input logic        out_ovf
);

  `TWRM_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_bits), "stalled result item changed or vanished")
  `TWRM_ASSERT(a_flags_hold, clk, rst, out_valid && !out_ready |=> $stable(out_final) && $stable(out_ovf), "stalled result flags changed")
  `TWRM_ASSERT(a_ovf_clean, clk, rst, out_valid && out_ovf |-> out_bits == 64'd0 && !out_final, "overflow item carries data")
  `TWRM_ASSERT(a_one_at_a_time, clk, rst, in_valid && in_ready |=> !in_ready, "item taken while previous one still in work")

endmodule

bind two_way_run_merger twrm_checker u_twrm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (feed.valid),
  .in_ready  (feed.ready),
  .out_valid (merged.valid),
  .out_ready (merged.ready),
  .out_bits  (merged.merged_bits),
  .out_final (merged.final_item),
  .out_ovf   (merged.overflow)
);

### tb/merge_order_check.sv
// Predicts the merged item stream from accepted feed items and compares it with the merger output.
`timescale 1ns / 1ps
module merge_order_check
  import twrm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              feed_valid,
  input  logic              feed_ready,
  input  logic              feed_run_select,
  input  logic              feed_has_value,
  input  logic [ELEM_W-1:0] feed_element_bits,
  input  logic              feed_run_end,
  input  logic              merged_valid,
  input  logic              merged_ready,
  input  logic [ELEM_W-1:0] merged_bits,
  input  logic              merged_final_item,
  input  logic              merged_overflow,
  output int                mismatches,
  output int                outstanding
);

  typedef struct packed {
    logic [ELEM_W-1:0] bits;
    logic              final_item;
    logic              overflow;
  } merged_rec_t;

  merged_rec_t       due_q[$];
  merged_rec_t       want;
  logic [ELEM_W-1:0] run_a_store [FIFO_DEPTH];
  logic [ELEM_W-1:0] run_b_store [FIFO_DEPTH];
  int unsigned       queued_a, queued_b;
  int unsigned       head_a, head_b;
  logic              done_a, done_b;

  function automatic logic [ELEM_W-1:0] sort_key(input logic [ELEM_W-1:0] bits);
    if (bits[ELEM_W-1]) return ~bits;
    return {1'b1, bits[ELEM_W-2:0]};
  endfunction

  function automatic logic not_above(input logic [ELEM_W-1:0] a, input logic [ELEM_W-1:0] b);
    logic [ELEM_W-1:0] both;
    both = a | b;
    if (both[ELEM_W-2:0] == '0) return 1'b1;
    return sort_key(a) <= sort_key(b);
  endfunction

  task automatic absorb_item(input logic sel_b, input logic has_value,
                             input logic [ELEM_W-1:0] elem, input logic ends);
    merged_rec_t rec;
    logic        take_a;
    if (!(sel_b ? done_b : done_a)) begin
      if (has_value && (sel_b ? queued_b : queued_a) >= FIFO_DEPTH) begin
        rec.bits = '0;
        rec.final_item = 1'b0;
        rec.overflow = 1'b1;
        due_q.insert(due_q.size(), rec);
        return;
      end
      if (has_value) begin
        if (sel_b) begin
          run_b_store[AW'((head_b + queued_b) % FIFO_DEPTH)] = elem;
          queued_b++;
        end else begin
          run_a_store[AW'((head_a + queued_a) % FIFO_DEPTH)] = elem;
          queued_a++;
        end
      end
      if (ends) begin
        if (sel_b) done_b = 1'b1;
        else done_a = 1'b1;
      end
    end
    while ((queued_a > 0 || done_a) && (queued_b > 0 || done_b) &&
           (queued_a + queued_b) > 0) begin
      if (queued_a > 0 && queued_b > 0)
        take_a = not_above(run_a_store[AW'(head_a)], run_b_store[AW'(head_b)]);
      else take_a = (queued_a > 0);
      if (take_a) begin
        rec.bits = run_a_store[AW'(head_a)];
        head_a = (head_a + 1) % FIFO_DEPTH;
        queued_a--;
      end else begin
        rec.bits = run_b_store[AW'(head_b)];
        head_b = (head_b + 1) % FIFO_DEPTH;
        queued_b--;
      end
      rec.final_item = done_a && done_b && queued_a == 0 && queued_b == 0;
      rec.overflow = 1'b0;
      due_q.insert(due_q.size(), rec);
    end
    if (done_a && done_b && queued_a == 0 && queued_b == 0) begin
      done_a = 1'b0;
      done_b = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      due_q.delete();
      queued_a = 0;
      queued_b = 0;
      head_a = 0;
      head_b = 0;
      done_a = 1'b0;
      done_b = 1'b0;
    end else begin
      if (merged_valid && merged_ready) begin
        if (due_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected merged item: expected none, got bits=%h final=%b overflow=%b",
                   $time, merged_bits, merged_final_item, merged_overflow);
        end else begin
          want = due_q.pop_front();
          if (want.bits !== merged_bits || want.final_item !== merged_final_item ||
              want.overflow !== merged_overflow) begin
            mismatches++;
            $display({"%0t: merged item mismatch: expected bits=%h final=%b overflow=%b, ",
                      "got bits=%h final=%b overflow=%b"},
                     $time, want.bits, want.final_item, want.overflow,
                     merged_bits, merged_final_item, merged_overflow);
          end
        end
      end
      if (feed_valid && feed_ready)
        absorb_item(feed_run_select, feed_has_value, feed_element_bits, feed_run_end);
    end
    outstanding <= due_q.size();
  end

endmodule

### tb/two_way_run_merger_tb.sv
// Stimulus, clock, reset and verdict for the two-way run merger.
`timescale 1ns / 1ps
module two_way_run_merger_tb;
  import twrm_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int ITEMS_PER_PHASE = 110;

  logic clk;
  logic rst;
  int   tx_idle_pct = 16;
  int   rx_idle_pct = 62;
  int   mismatches;
  int   outstanding;
  int   stall_cycles;

  twrm_in_if  feed();
  twrm_out_if merged();

  two_way_run_merger DUT (
    .clk    (clk),
    .rst    (rst),
    .feed   (feed),
    .merged (merged)
  );

  merge_order_check order_check (
    .clk               (clk),
    .rst               (rst),
    .feed_valid        (feed.valid),
    .feed_ready        (feed.ready),
    .feed_run_select   (feed.run_select),
    .feed_has_value    (feed.has_value),
    .feed_element_bits (feed.element_bits),
    .feed_run_end      (feed.run_end),
    .merged_valid      (merged.valid),
    .merged_ready      (merged.ready),
    .merged_bits       (merged.merged_bits),
    .merged_final_item (merged.final_item),
    .merged_overflow   (merged.overflow),
    .mismatches        (mismatches),
    .outstanding       (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    merged.ready = 1'b0;
    forever begin
      @(negedge clk);
      merged.ready = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (feed.valid && feed.ready) || (merged.valid && merged.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("two_way_run_merger_tb NOT OK");
        $finish;
      end
    end
  end

  task automatic offer(input logic sel, input logic hv, input logic [ELEM_W-1:0] bits,
                       input logic re);
    while ($urandom_range(99) < tx_idle_pct) begin
      feed.valid = 1'b0;
      feed.run_select = 1'($urandom_range(1));
      feed.has_value = 1'($urandom_range(1));
      feed.element_bits = {$urandom, $urandom};
      feed.run_end = 1'($urandom_range(1));
      @(negedge clk);
    end
    feed.valid = 1'b1;
    feed.run_select = sel;
    feed.has_value = hv;
    feed.element_bits = bits;
    feed.run_end = re;
    do @(posedge clk); while (!feed.ready);
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    feed.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin
    int                phase;
    int                sent;
    int                r;
    int                k;
    int                run_len [2];
    logic              flood;
    logic              tail_end [2];
    logic              closed [2];
    logic [ELEM_W-1:0] key;
    logic [ELEM_W-1:0] step;
    logic [ELEM_W-1:0] run_vals [2][$];
    logic [ELEM_W-1:0] v;

    rst = 1'b1;
    feed.valid = 1'b0;
    feed.run_select = 1'b0;
    feed.has_value = 1'b0;
    feed.element_bits = '0;
    feed.run_end = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    offer(1'b0, 1'b1, 64'h8000000000000000, 1'b0);
    offer(1'b1, 1'b1, 64'h0000000000000000, 1'b0);
    offer(1'b1, 1'b1, 64'h7FF0000000000000, 1'b0);
    offer(1'b0, 1'b1, 64'h0000000000000000, 1'b0);
    offer(1'b0, 1'b1, 64'hFFF0000000000000, 1'b0);
    offer(1'b0, 1'b0, 64'hFFFFFFFFFFFFFFFF, 1'b1);
    offer(1'b1, 1'b0, 64'h0000000000000000, 1'b1);
    offer(1'b1, 1'b1, 64'h5555555555555555, 1'b0);
    offer(1'b0, 1'b0, 64'hAAAAAAAAAAAAAAAA, 1'b0);
    offer(1'b0, 1'b0, 64'h0000000000000000, 1'b1);
    offer(1'b0, 1'b1, 64'hFFF8000000000000, 1'b0);
    offer(1'b1, 1'b1, 64'hFFF0000000000000, 1'b0);
    offer(1'b1, 1'b1, 64'h7FF8000000000001, 1'b1);
    offer(1'b1, 1'b1, 64'h3FF0000000000000, 1'b0);
    offer(1'b0, 1'b1, 64'hFFFFFFFFFFFFFFFF, 1'b0);
    offer(1'b0, 1'b1, 64'h7FFFFFFFFFFFFFFF, 1'b1);
    offer(1'b0, 1'b1, 64'h0000000000000000, 1'b0);
    offer(1'b1, 1'b1, 64'h8000000000000000, 1'b1);
    offer(1'b0, 1'b1, 64'h8000000000000000, 1'b1);
    hold_until_drained();

    for (phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 62 : 0;
      rx_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 16 : 0;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        flood = (sent == 0) || ($urandom_range(19) == 0);
        run_len[0] = flood ? FIFO_DEPTH + $urandom_range(3) :
                     ($urandom_range(7) == 0) ? $urandom_range(24) : $urandom_range(8);
        run_len[1] = flood ? 1 + $urandom_range(2) :
                     ($urandom_range(7) == 0) ? $urandom_range(24) : $urandom_range(8);
        if (flood && phase == 1) begin
          k = run_len[0];
          run_len[0] = run_len[1];
          run_len[1] = k;
        end
        key = {$urandom, $urandom};
        for (r = 0; r < 2; r++) begin
          run_vals[r].delete();
          v = key;
          for (k = 0; k < run_len[r]; k++) begin
            case ($urandom_range(3))
              0: step = '0;
              1: step = 64'($urandom_range(3));
              default: step = {$urandom, $urandom} >> (12 + $urandom_range(51));
            endcase
            v = v + step;
            run_vals[r].insert(run_vals[r].size(),
                               v[ELEM_W-1] ? {1'b0, v[ELEM_W-2:0]} : ~v);
          end
          tail_end[r] = !flood && $urandom_range(1);
          closed[r] = 1'b0;
        end
        while (!closed[0] || !closed[1]) begin
          if ($urandom_range(11) == 0) begin
            offer(1'($urandom_range(1)), 1'b0, {$urandom, $urandom}, 1'b0);
            sent++;
          end else if ($urandom_range(39) == 0) begin
            offer(1'($urandom_range(1)), 1'($urandom_range(1)), {$urandom, $urandom},
                  1'($urandom_range(1)));
            sent++;
          end
          if (flood) r = closed[phase == 1 ? 1 : 0] ? (phase == 1 ? 0 : 1) : (phase == 1 ? 1 : 0);
          else if (closed[0]) r = 1;
          else if (closed[1]) r = 0;
          else r = $urandom_range(1);
          if (run_vals[r].size() != 0) begin
            v = run_vals[r].pop_front();
            closed[r] = (run_vals[r].size() == 0) && tail_end[r];
            offer(r[0], 1'b1, v, closed[r]);
          end else begin
            offer(r[0], 1'b0, {$urandom, $urandom}, 1'b1);
            closed[r] = 1'b1;
          end
          sent++;
        end
        if ($urandom_range(9) == 0) hold_until_drained();
      end
      hold_until_drained();
    end

    feed.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("two_way_run_merger_tb OK");
    end else begin
      $display("two_way_run_merger_tb NOT OK");
    end
    $finish;
  end

endmodule
